>>> sv/indexed_binary_heap_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// indexed_binary_heap_queue_unit_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef INDEXED_BINARY_HEAP_QUEUE_UNIT_MACROS_SVH
`define INDEXED_BINARY_HEAP_QUEUE_UNIT_MACROS_SVH

// Checked outside reset only
`define IBHQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked during reset as well
`define IBHQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/ibhq_pkg.sv
// ----------------------------------------------------------------------------
// ibhq_pkg
// Types, codes and sizes shared by the indexed binary heap queue.
// ----------------------------------------------------------------------------
package ibhq_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int NUM_ELEM     = 1024;
	localparam int ELEM_W       = 10;
	localparam int KEY_W        = 32;
	localparam int COUNT_W      = 11;

	// commands
	localparam logic [1:0] CMD_INS = 2'd0;
	localparam logic [1:0] CMD_REM = 2'd1;
	localparam logic [1:0] CMD_UPD = 2'd2;
	localparam logic [1:0] CMD_CLR = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	// element colours
	localparam logic [1:0] COL_WHITE = 2'd0;
	localparam logic [1:0] COL_GRAY  = 2'd1;
	localparam logic [1:0] COL_BLACK = 2'd2;

	typedef struct packed {
		logic [1:0]              cmd;
		logic [ELEM_W-1:0]       element;
		logic signed [KEY_W-1:0] key;
	} in_t;

	typedef struct packed {
		logic [ELEM_W-1:0]       top_element;
		logic signed [KEY_W-1:0] top_key;
		logic [1:0]              status;
		logic [COUNT_W-1:0]      count;
	} out_t;

endpackage

>>> sv/ibhq_ram.sv
// ----------------------------------------------------------------------------
// ibhq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ibhq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> sv/indexed_binary_heap_queue_unit.sv
// An insert or update reads the element's colour; unless it is dropped as full or done, it
// then sifts the element up, comparing it with one parent at a time. A remove takes the top,
// moves the last element to the root and sifts it down against its children at each level.
// One command at a time, and a stalled result word holds off the next; a clear command sweeps
// every element colour to white. After reset, and after a change of the order bit, a colour
// sweep also runs, with in_ready low.
// ----------------------------------------------------------------------------
// indexed_binary_heap_queue_unit
// Indexed binary heap of element numbers keyed by signed costs, min or max first.
// ----------------------------------------------------------------------------
module indexed_binary_heap_queue_unit #(
	parameter int CAPACITY = ibhq_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ibhq_pkg::in_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output ibhq_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic          cfg_data
);
	import ibhq_pkg::*;

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CW     = SLOT_W + 2;
	localparam int EA_W   = $clog2(NUM_ELEM);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_RCOL  = 5'd1;
	localparam logic [4:0] S_COL   = 5'd2;
	localparam logic [4:0] S_SLOT  = 5'd3;
	localparam logic [4:0] S_UP    = 5'd4;
	localparam logic [4:0] S_UP1   = 5'd5;
	localparam logic [4:0] S_UP2   = 5'd6;
	localparam logic [4:0] S_RTOP  = 5'd7;
	localparam logic [4:0] S_TOP   = 5'd8;
	localparam logic [4:0] S_TOPK  = 5'd9;
	localparam logic [4:0] S_LAST  = 5'd10;
	localparam logic [4:0] S_LASTK = 5'd11;
	localparam logic [4:0] S_DN    = 5'd12;
	localparam logic [4:0] S_DN1   = 5'd13;
	localparam logic [4:0] S_DN2   = 5'd14;
	localparam logic [4:0] S_DN3   = 5'd15;
	localparam logic [4:0] S_DN4   = 5'd16;
	localparam logic [4:0] S_DN5   = 5'd17;
	localparam logic [4:0] S_CLR   = 5'd18;
	localparam logic [4:0] S_FIN   = 5'd19;

	logic [4:0]              state_q;
	logic [1:0]              cmd_q;
	logic [ELEM_W-1:0]       elem_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CNT_W-1:0]        fill_q;
	logic [SLOT_W-1:0]       idx_q;
	logic [ELEM_W-1:0]       x_q;
	logic signed [KEY_W-1:0] cx_q;
	logic [ELEM_W-1:0]       y_q;
	logic [ELEM_W-1:0]       cand_q;
	logic [ELEM_W-1:0]       best_e_q;
	logic signed [KEY_W-1:0] best_c_q;
	logic [SLOT_W-1:0]       best_slot_q;
	logic                    best_mv_q;
	logic [ELEM_W-1:0]       top_e_q;
	logic signed [KEY_W-1:0] top_k_q;
	logic [1:0]              status_q;
	logic [EA_W-1:0]         clr_q;
	logic                    clr_res_q;
	logic                    max_q;
	logic                    out_valid_q;
	out_t                    out_q;

	// store ports
	logic                    s_we, e_we, c_we, k_we;
	logic [SLOT_W-1:0]       s_wa, s_ra, e_wd, e_rd;
	logic [ELEM_W-1:0]       s_wd, s_rd;
	logic [EA_W-1:0]         e_wa, e_ra, c_wa, c_ra, k_wa, k_ra;
	logic signed [KEY_W-1:0] c_wd, c_rd;
	logic [1:0]              k_wd, k_rd;

	ibhq_ram #(.WIDTH(ELEM_W), .DEPTH(CAPACITY)) u_slot_ram (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
	);
	ibhq_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_ELEM)) u_eslot_ram (
		.clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd)
	);
	ibhq_ram #(.WIDTH(KEY_W), .DEPTH(NUM_ELEM)) u_cost_ram (
		.clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd)
	);
	ibhq_ram #(.WIDTH(2), .DEPTH(NUM_ELEM)) u_color_ram (
		.clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd)
	);

	// heap arithmetic on slot indices
	logic [SLOT_W-1:0] parent;
	logic [CW-1:0]     left_w, right_w, fill_w;
	logic              is_gray, is_black, full, cfg_change, fin_fire;
	logic              up_ahead, dn2_ahead, dn4_ahead;

	assign parent     = SLOT_W'((idx_q - 1'b1) >> 1);
	assign left_w     = CW'({idx_q, 1'b1});
	assign right_w    = left_w + CW'(1);
	assign fill_w     = CW'(fill_q);
	assign is_gray    = (k_rd == COL_GRAY);
	assign is_black   = (k_rd == COL_BLACK);
	assign full       = (fill_q >= CNT_W'(CAPACITY));
	assign cfg_change = cfg_we && (cfg_data != max_q);
	assign fin_fire   = (state_q == S_FIN) && (!out_valid_q || out_ready) && !cfg_change;

	// priority compare: a belongs nearer the root than b
	function automatic logic ahead(input logic mx, input logic signed [KEY_W-1:0] a,
			input logic signed [KEY_W-1:0] b);
		return mx ? (a > b) : (a < b);
	endfunction

	assign up_ahead  = ahead(max_q, cx_q, c_rd);
	assign dn2_ahead = ahead(max_q, c_rd, cx_q);
	assign dn4_ahead = ahead(max_q, c_rd, best_c_q);

	assign in_ready  = (state_q == S_IDLE) && !cfg_change;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// store addressing per state
	always_comb begin
		s_we = 1'b0; s_wa = idx_q; s_wd = x_q; s_ra = '0;
		e_we = 1'b0; e_wa = EA_W'(x_q); e_wd = idx_q; e_ra = EA_W'(elem_q);
		c_we = 1'b0; c_wa = EA_W'(elem_q); c_wd = key_q; c_ra = EA_W'(s_rd);
		k_we = 1'b0; k_wa = EA_W'(elem_q); k_wd = COL_GRAY; k_ra = EA_W'(elem_q);
		unique case (state_q)
			S_COL: begin
				if (cmd_q == CMD_UPD) begin
					c_we = 1'b1;
					k_we = !is_gray && !is_black && !full;
				end else begin
					c_we = is_gray || !full;
					k_we = !is_gray && !full;
				end
			end
			S_UP: begin
				s_ra = parent;
				if (idx_q == '0) begin
					s_we = 1'b1;
					e_we = 1'b1;
				end
			end
			S_UP2: begin
				s_we = 1'b1;
				e_we = 1'b1;
				if (up_ahead) begin
					s_wd = y_q;
					e_wa = EA_W'(y_q);
				end
			end
			S_TOPK: begin
				k_we = 1'b1;
				k_wa = EA_W'(top_e_q);
				k_wd = COL_BLACK;
				s_ra = SLOT_W'(fill_q - 1'b1);
			end
			S_DN: begin
				s_ra = SLOT_W'(left_w);
				if (left_w >= fill_w) begin
					s_we = 1'b1;
					e_we = 1'b1;
				end
			end
			S_DN2: begin
				s_ra = SLOT_W'(right_w);
			end
			S_DN5: begin
				s_we = 1'b1;
				e_we = 1'b1;
				if (best_mv_q) begin
					s_wd = best_e_q;
					e_wa = EA_W'(best_e_q);
				end
			end
			S_CLR: begin
				k_we = 1'b1;
				k_wa = clr_q;
				k_wd = COL_WHITE;
			end
			default: begin
			end
		endcase
	end

	// result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			clr_res_q   <= 1'b0;
			fill_q      <= '0;
			max_q       <= 1'b0;
		end else if (cfg_change) begin
			// a policy change clears the heap
			max_q     <= cfg_data;
			clr_q     <= '0;
			clr_res_q <= 1'b0;
			state_q   <= S_CLR;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q    <= in_data.cmd;
						elem_q   <= in_data.element;
						key_q    <= in_data.key;
						top_e_q  <= '0;
						top_k_q  <= '0;
						case (in_data.cmd) inside
							CMD_INS, CMD_UPD: begin
								status_q <= ST_OK;
								state_q  <= S_RCOL;
							end
							CMD_REM: begin
								if (fill_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_FIN;
								end else begin
									status_q <= ST_OK;
									state_q  <= S_RTOP;
								end
							end
							default: begin
								status_q  <= ST_OK;
								clr_q     <= '0;
								clr_res_q <= 1'b1;
								state_q   <= S_CLR;
							end
						endcase
					end
				end
				S_RCOL: state_q <= S_COL;
				S_COL: begin
					x_q  <= elem_q;
					cx_q <= key_q;
					if (is_gray) begin
						state_q <= S_SLOT;
					end else if (cmd_q == CMD_UPD && is_black) begin
						status_q <= ST_DONE;
						state_q  <= S_FIN;
					end else if (full) begin
						status_q <= ST_FULL;
						state_q  <= S_FIN;
					end else begin
						idx_q   <= SLOT_W'(fill_q);
						fill_q  <= fill_q + 1'b1;
						state_q <= S_UP;
					end
				end
				S_SLOT: begin
					idx_q   <= e_rd;
					state_q <= (CW'(e_rd) < fill_w) ? S_UP : S_FIN;
				end
				S_UP:  state_q <= (idx_q == '0) ? S_FIN : S_UP1;
				S_UP1: begin
					y_q     <= s_rd;
					state_q <= S_UP2;
				end
				S_UP2: begin
					if (up_ahead) begin
						idx_q   <= parent;
						state_q <= S_UP;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_RTOP: state_q <= S_TOP;
				S_TOP: begin
					top_e_q <= s_rd;
					state_q <= S_TOPK;
				end
				S_TOPK: begin
					top_k_q <= c_rd;
					fill_q  <= fill_q - 1'b1;
					state_q <= (fill_q == CNT_W'(1)) ? S_FIN : S_LAST;
				end
				S_LAST: begin
					x_q     <= s_rd;
					state_q <= S_LASTK;
				end
				S_LASTK: begin
					cx_q    <= c_rd;
					idx_q   <= '0;
					state_q <= S_DN;
				end
				S_DN: state_q <= (left_w < fill_w) ? S_DN1 : S_FIN;
				S_DN1: begin
					cand_q  <= s_rd;
					state_q <= S_DN2;
				end
				// left child against the moving element
				S_DN2: begin
					best_mv_q   <= dn2_ahead;
					best_e_q    <= cand_q;
					best_c_q    <= dn2_ahead ? c_rd : cx_q;
					best_slot_q <= SLOT_W'(left_w);
					state_q     <= (right_w < fill_w) ? S_DN3 : S_DN5;
				end
				S_DN3: begin
					cand_q  <= s_rd;
					state_q <= S_DN4;
				end
				// right child against the best so far
				S_DN4: begin
					if (dn4_ahead) begin
						best_mv_q   <= 1'b1;
						best_e_q    <= cand_q;
						best_slot_q <= SLOT_W'(right_w);
					end
					state_q <= S_DN5;
				end
				S_DN5: begin
					if (best_mv_q) begin
						idx_q   <= best_slot_q;
						state_q <= S_DN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == EA_W'(NUM_ELEM - 1)) begin
						fill_q  <= '0;
						state_q <= clr_res_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					if (fin_fire) begin
						out_q.top_element <= top_e_q;
						out_q.top_key     <= top_k_q;
						out_q.status      <= status_q;
						out_q.count       <= COUNT_W'(fill_q);
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> sv/ibhq_checker.sv
// ----------------------------------------------------------------------------
// ibhq_checker
// Port-level checks on the result channel of the heap queue.
// ----------------------------------------------------------------------------
`include "indexed_binary_heap_queue_unit_macros.svh"

module ibhq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input ibhq_pkg::out_t out_data
);
	import ibhq_pkg::*;

	`IBHQ_ASSERT_ALWAYS(a_no_word_in_reset, !arst_n |-> !out_valid, "result word during reset")
	`IBHQ_ASSERT(a_count_range, out_valid |-> out_data.count <= COUNT_W'(NUM_ELEM), "count too large")
	`IBHQ_ASSERT(a_empty_zero, out_valid && out_data.status == ST_EMPTY |-> out_data.top_element == '0 && out_data.top_key == '0 && out_data.count == '0, "empty remove not zero")
	`IBHQ_ASSERT(a_fail_no_top, out_valid && (out_data.status == ST_FULL || out_data.status == ST_DONE) |-> out_data.top_element == '0 && out_data.top_key == '0, "top set on failed command")
	`IBHQ_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled word changed")
endmodule

bind indexed_binary_heap_queue_unit ibhq_checker u_ibhq_checker (.*);

>>> bench/indexed_binary_heap_queue_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_binary_heap_queue_unit_test
// Checks the heap queue against a heap mirror kept in the bench. Every command
// word is mirrored when it is accepted. Each result word is compared field by
// field with the oldest word the mirror has worked out. Both handshakes idle
// at random. The order register is written between phases.
// ----------------------------------------------------------------------------
module indexed_binary_heap_queue_unit_test;
	import ibhq_pkg::*;

	localparam int SETTLE_CYCLES = 80;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;
	logic cfg_we;
	logic cfg_data;

	bit mismatch_seen;

	// heap mirror
	logic [ELEM_W-1:0]       mirror_slot_elem [CAPACITY_DEF];
	logic [ELEM_W-1:0]       mirror_elem_slot [NUM_ELEM];
	logic [1:0]              mirror_colour    [NUM_ELEM];
	logic signed [KEY_W-1:0] mirror_cost      [NUM_ELEM];
	int                      mirror_fill;
	logic                    mirror_max_first;

	out_t pending_results[$];

	indexed_binary_heap_queue_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard limit on the run
	initial begin
		#30_000_000;
		$display("Mismatches found");
		$finish;
	end

	// ---------------------------------------------------------------------
	// heap mirror
	// ---------------------------------------------------------------------
	function automatic bit goes_ahead(logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
		return mirror_max_first ? (mirror_cost[a] > mirror_cost[b])
		                        : (mirror_cost[a] < mirror_cost[b]);
	endfunction

	function automatic void swap_slots(int i, int j);
		logic [ELEM_W-1:0] t;
		t = mirror_slot_elem[i];
		mirror_slot_elem[i] = mirror_slot_elem[j];
		mirror_slot_elem[j] = t;
		mirror_elem_slot[mirror_slot_elem[i]] = ELEM_W'(i);
		mirror_elem_slot[mirror_slot_elem[j]] = ELEM_W'(j);
	endfunction

	function automatic void sift_toward_root(int i);
		int p;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!goes_ahead(mirror_slot_elem[i], mirror_slot_elem[p]))
				break;
			swap_slots(i, p);
			i = p;
		end
	endfunction

	function automatic void sift_toward_leaves(int i);
		int l, r, best;
		forever begin
			l = 2 * i + 1;
			r = 2 * i + 2;
			best = i;
			if (l < mirror_fill && goes_ahead(mirror_slot_elem[l], mirror_slot_elem[best]))
				best = l;
			if (r < mirror_fill && goes_ahead(mirror_slot_elem[r], mirror_slot_elem[best]))
				best = r;
			if (best == i)
				break;
			swap_slots(i, best);
			i = best;
		end
	endfunction

	function automatic void clear_mirror_heap();
		for (int k = 0; k < NUM_ELEM; k++) begin
			mirror_colour[k]    = COL_WHITE;
			mirror_elem_slot[k] = '0;
			mirror_slot_elem[k] = '0;
		end
		mirror_fill = 0;
	endfunction

	function automatic logic [1:0] enqueue_fresh(logic [ELEM_W-1:0] e);
		if (mirror_fill >= CAPACITY_DEF)
			return ST_FULL;
		mirror_slot_elem[mirror_fill] = e;
		mirror_elem_slot[e] = ELEM_W'(mirror_fill);
		mirror_colour[e] = COL_GRAY;
		mirror_fill++;
		sift_toward_root(mirror_fill - 1);
		return ST_OK;
	endfunction

	function automatic void raise_in_place(logic [ELEM_W-1:0] e);
		if (mirror_elem_slot[e] < mirror_fill)
			sift_toward_root(int'(mirror_elem_slot[e]));
	endfunction

	function automatic out_t heap_outcome(in_t w);
		out_t r;
		r = '0;
		case (w.cmd)
			CMD_INS: begin
				if (mirror_colour[w.element] == COL_GRAY) begin
					mirror_cost[w.element] = w.key;
					raise_in_place(w.element);
				end else if (mirror_fill >= CAPACITY_DEF) begin
					r.status = ST_FULL;
				end else begin
					mirror_cost[w.element] = w.key;
					r.status = enqueue_fresh(w.element);
				end
			end
			CMD_REM: begin
				if (mirror_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.top_element = mirror_slot_elem[0];
					r.top_key = mirror_cost[r.top_element];
					mirror_colour[r.top_element] = COL_BLACK;
					mirror_slot_elem[0] = mirror_slot_elem[mirror_fill - 1];
					mirror_elem_slot[mirror_slot_elem[0]] = '0;
					mirror_fill--;
					if (mirror_fill > 0)
						sift_toward_leaves(0);
				end
			end
			CMD_UPD: begin
				mirror_cost[w.element] = w.key;
				if (mirror_colour[w.element] == COL_BLACK)
					r.status = ST_DONE;
				else if (mirror_colour[w.element] == COL_GRAY)
					raise_in_place(w.element);
				else
					r.status = enqueue_fresh(w.element);
			end
			default: clear_mirror_heap();
		endcase
		r.count = COUNT_W'(mirror_fill);
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// result side: random stalls, compare against the oldest expectation
	// ---------------------------------------------------------------------
	initial begin
		int stall;
		out_t want;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_results.size() == 0) begin
				$display("%0t: result word with nothing expected: %p", $time, out_data);
				mismatch_seen = 1'b1;
			end else begin
				want = pending_results.pop_front();
				if (out_data.top_element !== want.top_element) begin
					$display("%0t: top_element expected %0d actual %0d", $time,
						want.top_element, out_data.top_element);
					mismatch_seen = 1'b1;
				end
				if (out_data.top_key !== want.top_key) begin
					$display("%0t: top_key expected %0d actual %0d", $time,
						want.top_key, out_data.top_key);
					mismatch_seen = 1'b1;
				end
				if (out_data.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, out_data.status);
					mismatch_seen = 1'b1;
				end
				if (out_data.count !== want.count) begin
					$display("%0t: count expected %0d actual %0d", $time,
						want.count, out_data.count);
					mismatch_seen = 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// command side
	// ---------------------------------------------------------------------
	// valid stays high across back-to-back words; it is only lowered for a gap
	task automatic send_word(logic [1:0] cmd, logic [ELEM_W-1:0] e, logic signed [KEY_W-1:0] k);
		int gap;
		in_t w;
		gap = $urandom_range(0, 4);
		w.cmd = cmd;
		w.element = e;
		w.key = k;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(heap_outcome(w));
	endtask

	// drop valid and let every result drain; results that never come are an error
	task automatic drain();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < 200_000) begin
			@(posedge clk);
			guard++;
		end
		if (pending_results.size() != 0) begin
			$display("%0t: results expected %0d actual %0d", $time,
				pending_results.size(), 0);
			mismatch_seen = 1'b1;
			pending_results.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_order(logic v);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (v != mirror_max_first) begin
			mirror_max_first = v;
			clear_mirror_heap();
		end
		@(posedge clk);
	endtask

	function automatic logic signed [KEY_W-1:0] any_key();
		case ($urandom_range(0, 5))
			0: return $signed({1'b1, 31'd0});
			1: return $signed({1'b0, {31{1'b1}}});
			2: return $signed(KEY_W'($urandom_range(0, 15)) - 8);
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic logic [ELEM_W-1:0] any_element(bit few);
		return few ? ELEM_W'($urandom_range(0, 23)) : ELEM_W'($urandom);
	endfunction

	// extremes and each special case by hand
	task automatic test_directed();
		send_word(CMD_REM, 10'd0, 32'sd0);                 // empty heap
		send_word(CMD_INS, 10'd0, $signed({1'b0, {31{1'b1}}}));
		send_word(CMD_INS, 10'd1023, $signed({1'b1, 31'd0}));
		send_word(CMD_INS, 10'd5, 32'sd7);
		send_word(CMD_INS, 10'd5, -32'sd3);                // queued: sift in place
		send_word(CMD_UPD, 10'd9, 32'sd100);               // never queued: insert
		send_word(CMD_UPD, 10'd9, -32'sd50);               // decrease key
		send_word(CMD_UPD, 10'd1023, 32'sd2000);           // raise: order may break
		send_word(CMD_REM, 10'd0, 32'sd0);
		send_word(CMD_REM, 10'd0, 32'sd0);
		send_word(CMD_UPD, 10'd1023, 32'sd1);              // done element
		send_word(CMD_UPD, 10'd9, 32'sd4);
		send_word(CMD_INS, 10'd1023, 32'sd11);             // done element queued again
		send_word(CMD_REM, 10'd0, 32'sd0);
		send_word(CMD_CLR, 10'd0, 32'sd0);
		send_word(CMD_REM, 10'd0, 32'sd0);
		send_word(CMD_INS, 10'd0, 32'sd0);
		send_word(CMD_INS, 10'd682, -32'sd1);
		send_word(CMD_REM, 10'd341, 32'sd5);
		send_word(CMD_REM, 10'd0, 32'sd0);
		send_word(CMD_REM, 10'd0, 32'sd0);
		drain();
	endtask

	// fill to capacity, then insert into a full heap
	task automatic test_full_heap();
		send_word(CMD_CLR, 10'd0, 32'sd0);
		for (int k = 0; k < NUM_ELEM; k++)
			send_word(CMD_INS, ELEM_W'(k), any_key());
		send_word(CMD_UPD, 10'd17, any_key());             // queued: sift in place
		send_word(CMD_INS, 10'd3, any_key());              // queued, full: still ok
		send_word(CMD_REM, 10'd0, 32'sd0);
		send_word(CMD_INS, 10'd700, any_key());
		send_word(CMD_INS, 10'd701, any_key());            // queued: sift in place
		send_word(CMD_UPD, 10'd4, any_key());
		for (int k = 0; k < 12; k++)
			send_word(CMD_REM, 10'd0, 32'sd0);
		send_word(CMD_CLR, 10'd0, 32'sd0);
		drain();
	endtask

	// mostly well formed traffic on a small element set, the rest anywhere
	task automatic test_random_traffic(int words);
		int pick;
		for (int n = 0; n < words; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send_word(CMD_INS, any_element($urandom_range(0, 3) != 0), any_key());
			else if (pick < 72)
				send_word(CMD_REM, ELEM_W'($urandom), $signed($urandom));
			else if (pick < 98)
				send_word(CMD_UPD, any_element($urandom_range(0, 3) != 0), any_key());
			else
				send_word(CMD_CLR, ELEM_W'($urandom), $signed($urandom));
		end
		drain();
	endtask

	// order register: both values, an equal write, and a change with a non-empty heap
	task automatic test_order_switch();
		write_order(1'b1);
		test_random_traffic(150);
		write_order(1'b1);
		test_random_traffic(60);
		write_order(1'b0);
		test_random_traffic(150);
		send_word(CMD_INS, 10'd2, 32'sd9);
		drain();
		write_order(1'b1);                                  // clears queued elements
		test_directed();
		write_order(1'b0);
	endtask

	// ---------------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_data  = 1'b0;
		mismatch_seen = 1'b0;
		mirror_max_first = 1'b0;
		clear_mirror_heap();
		for (int k = 0; k < NUM_ELEM; k++)
			mirror_cost[k] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(250);
		test_order_switch();
		test_full_heap();

		if (!mismatch_seen && pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/ibhq_pkg.sv
sv/ibhq_ram.sv
sv/indexed_binary_heap_queue_unit.sv
sv/ibhq_checker.sv
bench/indexed_binary_heap_queue_unit_test.sv
